[design/sweep_adsr_voice_synth_macros.svh]
// Assertion macros used by the checker file.
`ifndef SWEEP_ADSR_VOICE_SYNTH_MACROS_SVH
`define SWEEP_ADSR_VOICE_SYNTH_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SAVS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("savs check failed");

// next-cycle implication
`define SAVS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("savs check failed");

`endif

[design/savs_pkg.sv]
`default_nettype none
package savs_pkg;

	localparam int UNIT = 32768;
	localparam int FULL_SCALE = 32000;
	localparam logic [15:0] NOISE_SEED = 16'hACE1;
	localparam logic [15:0] NOISE_TAPS = 16'hB400;

	// quarter-wave sine entry, Q30 Horner series rounded to Q15, capped at UNIT (32768)
	function automatic logic [16:0] sine_entry(input logic [63:0] idx, input int qbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] v;
		logic [63:0] one;
		one = 64'd1 << 30;
		x = (idx * 64'd1686629713) >> qbits;
		x2 = (x * x) >> 30;
		t = one - x2 / 64'd110;
		t = one - ((x2 * t) >> 30) / 64'd72;
		t = one - ((x2 * t) >> 30) / 64'd42;
		t = one - ((x2 * t) >> 30) / 64'd20;
		t = one - ((x2 * t) >> 30) / 64'd6;
		v = (x * t) >> 30;
		v = (v + 64'd16384) >> 15;
		if (v > 64'd32768) begin
			v = 64'd32768;
		end
		return v[16:0];
	endfunction

endpackage
`default_nettype wire

[design/sweep_adsr_voice_synth.sv]
// Chirped sound-effect voice with an ADSR envelope, one PCM sample per input word.
// Input channel (in_valid/in_ready, restart): each word is one audio tick; restart=1
// clears the sample count, phase and phase step before the tick is computed.
// Output channel (out_valid/out_ready): sample, playing, final_res, one word per input.
// Config port: cfg_we/cfg_index/cfg_data writes register cfg_index;
// write only while the voice is idle.
// Flow: the sequencer works on one word at a time. A playing tick in attack divides,
// one in decay or release first forms the envelope numerator product and then divides,
// and one in sustain goes straight to the taps. The cost is set by the bit-serial shift-add
// multiplier (a load, then a shift-add step for each gain bit, over 8 taps, and for each
// envelope bit in the envelope product), the envelope numerator product in decay and
// release, and the restoring divider for the envelope ramps (a start step, then the
// quotient bits). A tick past the end of the effect goes from ENV straight to DONE and
// returns zero. in_ready is high only while the sequencer is idle, so the next word is
// taken only once the last one has left DONE.
// Reset: config and sequencer state reset, noise LFSR seeded to 0xACE1; datapath and output data are not.
// Stall: a finished word waits in the output register; the next tick may be accepted
// and computed, but it holds at its last step until the output register frees.
`default_nettype none
module sweep_adsr_voice_synth #(
	parameter int SINE_ENTRIES = 256,
	parameter int COUNT_BITS = 20,
	parameter int PHASE_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               restart,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      sample,
	output logic                    playing,
	output logic                    final_res,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [63:0]        cfg_data
);
	localparam int PB = PHASE_BITS;
	localparam int SB = $clog2(SINE_ENTRIES);
	localparam int QB = SB - 2;
	localparam int QUARTER = SINE_ENTRIES / 4;
	localparam int TW = ((COUNT_BITS > 20) ? COUNT_BITS : 20) + 2;
	localparam int PW = 44;     // accumulator: 27-bit mix times 16-bit envelope

	// register indexes
	localparam logic [2:0] REG_START   = 3'd0;
	localparam logic [2:0] REG_SWEEP   = 3'd1;
	localparam logic [2:0] REG_GAINS   = 3'd2;
	localparam logic [2:0] REG_ATTACK  = 3'd3;
	localparam logic [2:0] REG_DECAY   = 3'd4;
	localparam logic [2:0] REG_SUSTAIN = 3'd5;
	localparam logic [2:0] REG_RELEASE = 3'd6;
	localparam logic [2:0] REG_TOTAL   = 3'd7;

	// sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_ENV    = 4'd1;
	localparam logic [3:0] ST_NMUL   = 4'd2;
	localparam logic [3:0] ST_DSTART = 4'd3;
	localparam logic [3:0] ST_DIV    = 4'd4;
	localparam logic [3:0] ST_TAP    = 4'd5;
	localparam logic [3:0] ST_MUL    = 4'd6;
	localparam logic [3:0] ST_PLOAD  = 4'd7;
	localparam logic [3:0] ST_PMUL   = 4'd8;
	localparam logic [3:0] ST_CLAMP  = 4'd9;
	localparam logic [3:0] ST_SCALE  = 4'd10;
	localparam logic [3:0] ST_PH1    = 4'd11;
	localparam logic [3:0] ST_PH2    = 4'd12;
	localparam logic [3:0] ST_PH3    = 4'd13;
	localparam logic [3:0] ST_DONE   = 4'd14;

	// envelope segments
	localparam logic [1:0] SEG_ATT = 2'd0;
	localparam logic [1:0] SEG_DEC = 2'd1;
	localparam logic [1:0] SEG_SUS = 2'd2;
	localparam logic [1:0] SEG_REL = 2'd3;

	// tap order within the mix
	localparam logic [2:0] TAP_SQR_F  = 3'd0;
	localparam logic [2:0] TAP_SIN_F  = 3'd1;
	localparam logic [2:0] TAP_SIN_H  = 3'd2;
	localparam logic [2:0] TAP_SQR_H  = 3'd3;
	localparam logic [2:0] TAP_SIN_D  = 3'd4;
	localparam logic [2:0] TAP_TRI_D  = 3'd5;
	localparam logic [2:0] TAP_TRI_T  = 3'd6;
	localparam logic [2:0] TAP_NOISE  = 3'd7;

	localparam logic [PW-1:0] CLAMP = PW'(1) << 38;

	// configuration
	logic        [30:0] start_q;
	logic signed [20:0] sweep_q;
	logic        [63:0] gains_q;
	logic        [15:0] attack_q;
	logic        [15:0] decay_q;
	logic        [15:0] sustain_q;
	logic        [15:0] release_q;
	logic        [19:0] total_q;

	// voice state
	logic [COUNT_BITS-1:0] count_q;
	logic [PB:0]           phase_q;
	logic [PB:0]           step_q;
	logic [15:0]           noise_q;

	// sequencer and datapath
	logic [3:0]           state_q;
	logic [1:0]           seg_q;
	logic [2:0]           tap_q;
	logic [4:0]           cnt_q;
	logic signed [PW-1:0] acc_q;
	logic signed [PW-1:0] mcand_q;
	logic [15:0]          mplr_q;
	logic [15:0]          env_q;
	logic [38:0]          mag_q;
	logic                 neg_q;
	logic [15:0]          pcm_q;
	logic                 play_q;
	logic                 last_q;

	// output register
	logic                 out_valid_q;
	logic [15:0]          sample_q;
	logic                 playing_q;
	logic                 final_q;

	// ---------------- configuration writes ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			sweep_q <= '0;
			gains_q <= '0;
			attack_q <= 16'd1;
			decay_q <= 16'd1;
			sustain_q <= '0;
			release_q <= 16'd1;
			total_q <= 20'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START:   start_q <= cfg_data[30:0];
				REG_SWEEP:   sweep_q <= cfg_data[20:0];
				REG_GAINS:   gains_q <= cfg_data;
				REG_ATTACK:  attack_q <= cfg_data[15:0];
				REG_DECAY:   decay_q <= cfg_data[15:0];
				REG_SUSTAIN: sustain_q <= cfg_data[15:0];
				REG_RELEASE: release_q <= cfg_data[15:0];
				REG_TOTAL:   total_q <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// ---------------- envelope segment decode ----------------
	logic signed [TW-1:0] t_s;
	logic signed [TW-1:0] a_s;
	logic signed [TW-1:0] ad_s;
	logic signed [TW-1:0] rs_s;
	logic signed [TW-1:0] l_s;
	logic signed [TW-1:0] dec_off;
	logic signed [TW-1:0] rel_off;
	logic        [15:0]   sus_sat;
	logic        [16:0]   sus_gap;

	always_comb begin
		t_s = TW'(count_q);
		a_s = TW'(attack_q);
		ad_s = TW'(attack_q) + TW'(decay_q);
		l_s = TW'(total_q);
		rs_s = TW'(total_q) - TW'(release_q);   // may go negative
		dec_off = t_s - a_s;
		rel_off = l_s - t_s;
		sus_sat = (sustain_q > 16'(savs_pkg::UNIT)) ? 16'(savs_pkg::UNIT) : sustain_q;
		sus_gap = 17'(savs_pkg::UNIT) - {1'b0, sus_sat};
	end

	// ---------------- divider ----------------
	logic        div_start;
	logic [30:0] div_numer;
	logic [15:0] div_denom;
	logic        div_done;
	logic [30:0] div_quot;

	assign div_start = (state_q == ST_DSTART);
	assign div_numer = (seg_q == SEG_ATT) ? {t_s[15:0], 15'b0} : acc_q[30:0];

	always_comb begin
		case (seg_q)
			SEG_ATT: div_denom = attack_q;
			SEG_DEC: div_denom = decay_q;
			default: div_denom = release_q;
		endcase
	end

	savs_div #(
		.NUM_W(31),
		.DEN_W(16)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.numer(div_numer),
		.denom(div_denom),
		.done(div_done),
		.quot(div_quot)
	);

	// ---------------- waveform taps ----------------
	logic [16:0] sine_rom [QUARTER+1];

	for (genvar g = 0; g <= QUARTER; g++) begin : g_sine
		assign sine_rom[g] = savs_pkg::sine_entry(64'(g), QB);
	end

	logic [PB-1:0]        frac0;
	logic [PB-1:0]        frac_h;
	logic [PB-1:0]        frac_d;
	logic [PB:0]          triple;
	logic [PB-1:0]        sfrac;
	logic [PB-1:0]        tfrac;
	logic [SB-1:0]        sk;
	logic [QB:0]          sidx;
	logic [16:0]          sv;
	logic signed [17:0]   sine_val;
	logic [15:0]          tu;
	logic signed [17:0]   tri_val;
	logic                 sq_bit;
	logic signed [17:0]   sq_val;
	logic signed [17:0]   noise_val;
	logic signed [17:0]   tap_val;

	always_comb begin
		frac0 = phase_q[PB-1:0];
		frac_h = phase_q[PB:1];
		frac_d = {phase_q[PB-2:0], 1'b0};
		triple = phase_q + {phase_q[PB-1:0], 1'b0};
		case (tap_q)
			TAP_SIN_F: sfrac = frac0;
			TAP_SIN_H: sfrac = frac_h;
			default:   sfrac = frac_d;
		endcase
		sk = sfrac[PB-1 -: SB];
		sidx = sk[SB-2] ? ((QB+1)'(QUARTER) - {1'b0, sk[QB-1:0]}) : {1'b0, sk[QB-1:0]};
		sv = sine_rom[sidx];
		sine_val = sk[SB-1] ? -$signed({1'b0, sv}) : $signed({1'b0, sv});

		tfrac = (tap_q == TAP_TRI_D) ? frac_d : triple[PB-1:0];
		tu = tfrac[PB-1 -: 16];
		if (tu < 16'd16384) begin
			tri_val = {1'b0, tu, 1'b0};
		end else if (tu < 16'd49152) begin
			tri_val = 18'sd65536 - $signed({1'b0, tu, 1'b0});
		end else begin
			tri_val = $signed({1'b0, tu, 1'b0}) - 18'sd131072;
		end

		sq_bit = (tap_q == TAP_SQR_H) ? phase_q[PB] : frac0[PB-1];
		sq_val = sq_bit ? -18'sd32768 : 18'sd32768;
		noise_val = $signed({2'b0, noise_q}) - 18'sd32768;

		case (tap_q)
			TAP_SQR_F, TAP_SQR_H:            tap_val = sq_val;
			TAP_SIN_F, TAP_SIN_H, TAP_SIN_D: tap_val = sine_val;
			TAP_TRI_D, TAP_TRI_T:            tap_val = tri_val;
			TAP_NOISE:                       tap_val = noise_val;
			default:                         tap_val = noise_val;
		endcase
	end

	// ---------------- shift-add step, clamp, scale ----------------
	logic signed [PW-1:0] acc_add;
	logic        [PW-1:0] acc_abs;
	logic        [45:0]   m46;
	logic        [45:0]   scaled;
	logic        [PB:0]   start_ext;
	logic        [PB:0]   sweep_ext;
	logic                 out_free;

	always_comb begin
		acc_add = acc_q + (mplr_q[0] ? mcand_q : PW'(0));
		acc_abs = acc_q[PW-1] ? 44'(-acc_q) : 44'(acc_q);
		m46 = 46'(mag_q);
		scaled = (m46 << 7) - (m46 << 1) - m46;  // x125; 32000 = 125 * 2^8
		start_ext = (PB+1)'(start_q);
		sweep_ext = (PB+1)'(sweep_q);
		out_free = !out_valid_q || out_ready;
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			phase_q <= '0;
			step_q <= '0;
			noise_q <= savs_pkg::NOISE_SEED;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (restart) begin
							count_q <= '0;
							phase_q <= '0;
							step_q <= '0;
						end
						state_q <= ST_ENV;
					end
				end
				ST_ENV: begin
					if (t_s >= l_s) begin
						state_q <= ST_DONE;
					end else if (t_s < a_s) begin
						state_q <= ST_DSTART;
					end else if (t_s < ad_s) begin
						state_q <= ST_NMUL;
					end else if (t_s < rs_s) begin
						state_q <= ST_TAP;
					end else begin
						state_q <= ST_NMUL;
					end
				end
				ST_NMUL: begin
					if (cnt_q == 5'd1) begin
						state_q <= ST_DSTART;
					end
				end
				ST_DSTART: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_TAP;
					end
				end
				ST_TAP: state_q <= ST_MUL;
				ST_MUL: begin
					if (cnt_q == 5'd1) begin
						state_q <= (tap_q == TAP_NOISE) ? ST_PLOAD : ST_TAP;
					end
				end
				ST_PLOAD: state_q <= ST_PMUL;
				ST_PMUL: begin
					if (cnt_q == 5'd1) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_PH1;
				ST_PH1: begin
					phase_q <= phase_q + step_q;
					state_q <= ST_PH2;
				end
				ST_PH2: begin
					phase_q <= phase_q + start_ext;
					state_q <= ST_PH3;
				end
				ST_PH3: begin
					phase_q <= phase_q + sweep_ext;
					step_q <= step_q + {sweep_ext[PB-1:0], 1'b0};
					if (count_q != '1) begin
						count_q <= count_q + 1'b1;
					end
					noise_q <= noise_q[0] ? ((noise_q >> 1) ^ savs_pkg::NOISE_TAPS)
						: (noise_q >> 1);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_ENV: begin
				play_q <= (t_s < l_s);
				last_q <= (t_s == l_s - TW'(1));
				pcm_q <= '0;
				acc_q <= '0;
				cnt_q <= 5'd16;
				tap_q <= TAP_SQR_F;
				if (t_s < a_s) begin
					seg_q <= SEG_ATT;
				end else if (t_s < ad_s) begin
					seg_q <= SEG_DEC;
					mcand_q <= PW'(sus_gap);
					mplr_q <= dec_off[15:0];
				end else if (t_s < rs_s) begin
					seg_q <= SEG_SUS;
					env_q <= sus_sat;
				end else begin
					seg_q <= SEG_REL;
					mcand_q <= PW'(sus_sat);
					mplr_q <= rel_off[15:0];
				end
			end
			ST_NMUL, ST_MUL, ST_PMUL: begin
				acc_q <= acc_add;
				mcand_q <= mcand_q <<< 1;
				mplr_q <= mplr_q >> 1;
				cnt_q <= cnt_q - 1'b1;
				if (state_q == ST_MUL && cnt_q == 5'd1) begin
					tap_q <= tap_q + 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					env_q <= (seg_q == SEG_DEC)
						? 16'(17'(savs_pkg::UNIT) - {1'b0, div_quot[15:0]})
						: div_quot[15:0];
					acc_q <= '0;
				end
			end
			ST_TAP: begin
				mcand_q <= PW'(tap_val);
				mplr_q <= {8'b0, gains_q[tap_q*8 +: 8]};
				cnt_q <= 5'd8;
			end
			ST_PLOAD: begin
				mcand_q <= acc_q;
				mplr_q <= env_q;
				acc_q <= '0;
				cnt_q <= 5'd16;
			end
			ST_CLAMP: begin
				neg_q <= acc_q[PW-1];
				mag_q <= (acc_abs > CLAMP) ? 39'(CLAMP) : acc_abs[38:0];
			end
			ST_SCALE: begin
				pcm_q <= neg_q ? 16'(-scaled[45:30]) : scaled[45:30];
			end
			ST_DONE: begin
				if (out_free) begin
					sample_q <= pcm_q;
					playing_q <= play_q;
					final_q <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign sample = sample_q;
	assign playing = playing_q;
	assign final_res = final_q;
endmodule
`default_nettype wire

[design/savs_div.sv]
`default_nettype none
// restoring divider, one quotient bit per cycle
module savs_div #(
	parameter int NUM_W = 31,
	parameter int DEN_W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] numer,
	input  wire logic [DEN_W-1:0] denom,
	output logic                  done,
	output logic      [NUM_W-1:0] quot
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] diff;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign diff = {1'b0, shifted} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CW'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			if (!diff[DEN_W+1]) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule
`default_nettype wire

[design/savs_checker.sv]
`default_nettype none
`include "sweep_adsr_voice_synth_macros.svh"
module savs_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [15:0] sample,
	input wire logic               playing,
	input wire logic               final_res
);
	// a held word stays valid and keeps its sample
	`SAVS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample))
	// past the end of the effect the voice is silent
	`SAVS_ASSERT_IMP(a_idle_zero, out_valid && !playing, sample == 16'sd0 && !final_res)
	`SAVS_ASSERT_IMP(a_final_play, out_valid && final_res, playing)
	// clamp and scale keep the word within full scale
	`SAVS_ASSERT_IMP(a_range, out_valid,
		sample <= savs_pkg::FULL_SCALE && sample >= -savs_pkg::FULL_SCALE)
endmodule

bind sweep_adsr_voice_synth savs_checker u_savs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.sample(sample),
	.playing(playing),
	.final_res(final_res)
);
`default_nettype wire

[dv/sweep_adsr_voice_synth_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
// Testbench for the chirped ADSR voice.
// A short table of directed ticks runs first, then two directed phases and random
// phases. Each phase writes all eight registers while the voice is idle, then plays
// one effect: a run of ticks, most often opened by a restart word, that usually runs
// past the end of the effect. Every accepted word is predicted here. Results are
// checked field by field, in order.
module sweep_adsr_voice_synth_tb;

	// register indexes on the write port
	localparam logic [2:0] REG_START   = 3'd0;
	localparam logic [2:0] REG_SWEEP   = 3'd1;
	localparam logic [2:0] REG_GAINS   = 3'd2;
	localparam logic [2:0] REG_ATTACK  = 3'd3;
	localparam logic [2:0] REG_DECAY   = 3'd4;
	localparam logic [2:0] REG_SUSTAIN = 3'd5;
	localparam logic [2:0] REG_RELEASE = 3'd6;
	localparam logic [2:0] REG_TOTAL   = 3'd7;

	localparam int ITEM_GOAL = 1170;
	localparam longint CLIP = 64'sd1 << 38;
	localparam longint COUNT_TOP = (64'sd1 << 20) - 1;

	typedef struct packed {
		logic signed [15:0] pcm;
		logic               active;
		logic               last;
	} voice_word_t;

	typedef struct {
		bit          rs;
		bit          typed;
		voice_word_t want;
	} tick_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               restart;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] sample;
	logic               playing;
	logic               final_res;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [63:0]        cfg_data;

	sweep_adsr_voice_synth dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .restart(restart),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample(sample), .playing(playing), .final_res(final_res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// voice mirror: registers
	logic [30:0] m_start;
	logic signed [20:0] m_sweep;
	logic [63:0] m_gains;
	longint m_attack, m_decay, m_sustain, m_release, m_total;
	// voice mirror: running state
	longint      m_count;
	logic [32:0] m_phase;
	logic [32:0] m_step;
	logic [15:0] m_lfsr;
	int          qwave [0:64];

	voice_word_t expected_words[$];
	int          words_sent, words_seen, mismatches, phases;
	bit          no_gaps;
	int          rx_hold;   // long receiver hold-off, in cycles

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// quarter-wave sine, Q30 odd series through x^11, rounded to Q15
	initial begin
		longint unsigned x, x2, acc, v;
		for (int i = 0; i <= 64; i++) begin
			x = (longint'(i) * 64'd1686629713) / 64;
			x2 = (x * x) >> 30;
			acc = (64'd1 << 30) - x2 / 110;
			acc = (64'd1 << 30) - ((x2 * acc) >> 30) / 72;
			acc = (64'd1 << 30) - ((x2 * acc) >> 30) / 42;
			acc = (64'd1 << 30) - ((x2 * acc) >> 30) / 20;
			acc = (64'd1 << 30) - ((x2 * acc) >> 30) / 6;
			v = (((x * acc) >> 30) + 64'd16384) >> 15;
			qwave[i] = (v > 32768) ? 32768 : int'(v);
		end
	end

	function automatic longint sq_tap(logic [31:0] f);
		return f[31] ? -64'sd32768 : 64'sd32768;
	endfunction

	function automatic longint sin_tap(logic [31:0] f);
		longint v;
		v = f[30] ? qwave[64 - f[29:24]] : qwave[f[29:24]];
		return f[31] ? -v : v;
	endfunction

	function automatic longint tri_tap(logic [31:0] f);
		longint u;
		u = f[31:16];
		if (u < 16384) return 2 * u;
		if (u < 49152) return 65536 - 2 * u;
		return 2 * u - 131072;
	endfunction

	function automatic longint envelope_at(longint t);
		longint s;
		s = (m_sustain > 32768) ? 32768 : m_sustain;
		if (t < m_attack) return t * 32768 / m_attack;
		if (t < m_attack + m_decay) return 32768 - (32768 - s) * (t - m_attack) / m_decay;
		if (t < m_total - m_release) return s;
		if (t < m_total) return s * (m_total - t) / m_release;
		return 0;
	endfunction

	// advance the mirror by one tick and return the word it gives
	function automatic voice_word_t voice_tick(bit rs);
		voice_word_t w;
		longint taps [8];
		longint mix, prod;
		logic [63:0] tri3;
		logic [32:0] sw;
		if (rs) begin
			m_count = 0;
			m_phase = '0;
			m_step = '0;
		end
		w = '0;
		if (m_count < m_total) begin
			w.active = 1'b1;
			w.last = (m_count == m_total - 1);
			tri3 = 64'(m_phase) * 3;
			taps[0] = sq_tap(m_phase[31:0]);
			taps[1] = sin_tap(m_phase[31:0]);
			taps[2] = sin_tap(m_phase[32:1]);
			taps[3] = sq_tap(m_phase[32:1]);
			taps[4] = sin_tap({m_phase[30:0], 1'b0});
			taps[5] = tri_tap({m_phase[30:0], 1'b0});
			taps[6] = tri_tap(tri3[31:0]);
			taps[7] = longint'(m_lfsr) - 32768;
			mix = 0;
			for (int i = 0; i < 8; i++)
				mix += longint'(m_gains[8*i +: 8]) * taps[i];
			prod = mix * envelope_at(m_count);
			if (prod > CLIP) prod = CLIP;
			if (prod < -CLIP) prod = -CLIP;
			w.pcm = 16'(prod * 32000 / CLIP);
			sw = 33'(m_sweep);
			m_phase = m_phase + 33'(m_start) + sw + m_step;
			m_step = m_step + (sw << 1);
			if (m_count < COUNT_TOP) m_count++;
			m_lfsr = m_lfsr[0] ? ((m_lfsr >> 1) ^ 16'hB400) : (m_lfsr >> 1);
		end
		return w;
	endfunction

	// register write, only once the voice has drained
	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_START:   m_start = val[30:0];
			REG_SWEEP:   m_sweep = val[20:0];
			REG_GAINS:   m_gains = val;
			REG_ATTACK:  m_attack = val[15:0];
			REG_DECAY:   m_decay = val[15:0];
			REG_SUSTAIN: m_sustain = val[15:0];
			REG_RELEASE: m_release = val[15:0];
			default:     m_total = val[19:0];
		endcase
	endtask

	task automatic load_voice(logic [30:0] st, logic [20:0] sw, logic [63:0] g,
		logic [15:0] a, logic [15:0] d, logic [15:0] s, logic [15:0] r, logic [19:0] l);
		write_reg(REG_START, 64'(st));
		write_reg(REG_SWEEP, 64'(sw));
		write_reg(REG_GAINS, g);
		write_reg(REG_ATTACK, 64'(a));
		write_reg(REG_DECAY, 64'(d));
		write_reg(REG_SUSTAIN, 64'(s));
		write_reg(REG_RELEASE, 64'(r));
		write_reg(REG_TOTAL, 64'(l));
		phases++;
	endtask

	// offer one tick word; a typed row overrides the predicted word
	task automatic send_tick(bit rs, bit typed = 0, voice_word_t want = '0);
		int gap;
		voice_word_t w;
		gap = no_gaps ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= rs;
		do @(posedge clk); while (!in_ready);
		w = voice_tick(rs);
		expected_words.push_back(typed ? want : w);
		words_sent++;
	endtask

	// receiver: random stall per word, plus an occasional long hold-off
	initial begin
		int stall;
		voice_word_t got, want;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			stall = no_gaps ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = '{sample, playing, final_res};
			words_seen++;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: sample=%0d playing=%0b final=%0b",
						sample, playing, final_res);
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("word %0d: expected sample=%0d playing=%0b final=%0b",
							words_seen, want.pcm, want.active, want.last);
						$display("word %0d: got      sample=%0d playing=%0b final=%0b",
							words_seen, got.pcm, got.active, got.last);
					end
				end
			end
		end
	end

	// hard stop if the voice hangs
	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	tick_row_t rows[$];

	initial begin
		int n, hold_phase, pause_phase;
		logic [63:0] g;
		logic [19:0] l;
		arst_n = 1'b0;
		in_valid = 1'b0;
		restart = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_START;
		cfg_data = '0;
		no_gaps = 0;
		rx_hold = 0;
		words_sent = 0;
		words_seen = 0;
		mismatches = 0;
		phases = 0;
		m_start = '0; m_sweep = '0; m_gains = '0;
		m_attack = 1; m_decay = 1; m_sustain = 0; m_release = 1; m_total = 1;
		m_count = 0; m_phase = '0; m_step = '0; m_lfsr = 16'hACE1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: one-sample effect, all gains zero
		rows.push_back('{0, 1, '{16'sd0, 1'b1, 1'b1}});
		rows.push_back('{0, 1, '{16'sd0, 1'b0, 1'b0}});
		rows.push_back('{1, 1, '{16'sd0, 1'b1, 1'b1}});
		rows.push_back('{0, 1, '{16'sd0, 1'b0, 1'b0}});
		foreach (rows[i]) send_tick(rows[i].rs, rows[i].typed, rows[i].want);

		// extremes: top rate, most negative sweep, full gains, zero attack and
		// decay, sustain above full scale, release longer than the effect
		load_voice(31'h7FFF_FFFF, 21'h10_0000, '1, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 20'd12);
		rows.delete();
		rows.push_back('{1, 0, '0});
		for (int i = 0; i < 13; i++) rows.push_back('{0, 0, '0});
		foreach (rows[i]) send_tick(rows[i].rs);
		// opposite corner, with the effect left unfinished mid-way
		load_voice(31'd0, 21'h0F_FFFF, 64'h55AA_FF00_0180_7F01, 16'd3, 16'd4,
			16'd0, 16'd2, 20'd16);
		for (int i = 0; i < 7; i++) send_tick(i == 0);

		hold_phase = $urandom_range(3, 6);
		pause_phase = $urandom_range(7, 12);
		while (words_sent < ITEM_GOAL) begin
			case ($urandom_range(0, 3))
				0: g = '0;
				1: g = '1;
				2: g = 64'hFF << (8 * $urandom_range(0, 7));
				default: g = {$urandom, $urandom};
			endcase
			l = ($urandom_range(0, 15) == 0) ? 20'hF_FFFF : 20'($urandom_range(1, 90));
			load_voice(
				($urandom_range(0, 4) == 0) ? 31'h7FFF_FFFF : 31'($urandom),
				($urandom_range(0, 4) == 0) ? 21'h10_0000 : 21'($urandom),
				g,
				($urandom_range(0, 12) == 0) ? 16'hFFFF : 16'($urandom_range(0, 30)),
				($urandom_range(0, 12) == 0) ? 16'hFFFF : 16'($urandom_range(0, 30)),
				($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768)),
				($urandom_range(0, 12) == 0) ? 16'hFFFF : 16'($urandom_range(0, 40)),
				l);
			no_gaps = ($urandom_range(0, 5) == 0);
			n = (l > 100) ? 60 : int'(l) + $urandom_range(0, 8);
			if (phases == hold_phase) rx_hold = 800;
			for (int i = 0; i < n; i++) begin
				if (phases == pause_phase && i == n / 2) begin
					in_valid <= 1'b0;
					while (expected_words.size() != 0) @(posedge clk);
				end
				send_tick((i == 0 && $urandom_range(0, 4) != 0) || $urandom_range(0, 40) == 0);
			end
		end
		@(posedge clk);
		in_valid <= 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d tick words checked over %0d register settings", words_seen, phases);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
